@@ sv/successor_predictive_page_replacement_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the successor-predictive page replacement block
// Implication and next-cycle checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef SUCCESSOR_PREDICTIVE_PAGE_REPLACEMENT_MACROS_SVH
`define SUCCESSOR_PREDICTIVE_PAGE_REPLACEMENT_MACROS_SVH

`ifndef SYNTH
`define SPPR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sppr check failed");
`define SPPR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sppr check failed");
`else
`define SPPR_ASSERT_IMP(label, clk, rstn, ante, cons)
`define SPPR_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ sv/sppr_pkg.sv @@
// ---------------------------------------------------------------------------
// sppr_pkg
// Shared types and fixed field widths of the page replacement block.
// ---------------------------------------------------------------------------
package sppr_pkg;

    localparam int PAGE_W     = 4;
    localparam int SLOT_OUT_W = 2;
    localparam int TOTAL_W    = 32;
    localparam int CFG_W      = 3;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 3'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INC_RD,
        ST_INC_WR,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY,
        ST_OUT
    } sppr_state_t;

    // commands into the frame table
    typedef struct packed {
        logic fill;
        logic replace;
    } frame_cmd_t;

    // frame table status for the current page
    typedef struct packed {
        logic warm;
        logic hit;
    } frame_stat_t;

    // predicted successor pages, 1-based
    typedef struct packed {
        logic [PAGE_W-1:0] first_page;
        logic [PAGE_W-1:0] second_page;
    } rank_result_t;

endpackage

@@ sv/sppr_count_mem.sv @@
// ---------------------------------------------------------------------------
// sppr_count_mem
// Successor count memory: one write and one registered read port, with a
// valid bit per entry so that unwritten entries read as zero after reset.
// ---------------------------------------------------------------------------
module sppr_count_mem #(
    parameter int DEPTH  = 81,
    parameter int ADDR_W = 7,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              rstn,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  vld_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_vld_reg;

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk) begin
        if (!rstn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

@@ sv/sppr_rank.sv @@
// ---------------------------------------------------------------------------
// sppr_rank
// Streaming rank tracker: takes one count of a row per cycle while sample is
// high; keeps highest-index maximum and highest-index second-sorted value.
// ---------------------------------------------------------------------------
module sppr_rank
    import sppr_pkg::*;
#(
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  logic                  clk,
    input  logic                  sample,
    input  logic [IDX_W-1:0]      col,
    input  logic [COUNT_BITS-1:0] value,
    output rank_result_t          result
);

    logic [COUNT_BITS-1:0] top_reg;
    logic [COUNT_BITS-1:0] sv_reg;
    logic [IDX_W-1:0]      tidx_reg;
    logic [IDX_W-1:0]      sidx_reg;
    logic                  multi_reg;
    logic                  have_reg;
    logic [IDX_W-1:0]      second_idx;

    always_ff @(posedge clk) begin
        if (sample) begin
            if (col == '0) begin
                top_reg   <= value;
                tidx_reg  <= col;
                multi_reg <= 1'b0;
                have_reg  <= 1'b0;
            end else if (value > top_reg) begin
                // old maximum drops to second place
                sv_reg    <= top_reg;
                sidx_reg  <= tidx_reg;
                have_reg  <= 1'b1;
                top_reg   <= value;
                tidx_reg  <= col;
                multi_reg <= 1'b0;
            end else if (value == top_reg) begin
                multi_reg <= 1'b1;
                tidx_reg  <= col;
            end else if (!have_reg || value > sv_reg) begin
                sv_reg   <= value;
                sidx_reg <= col;
                have_reg <= 1'b1;
            end else if (value == sv_reg) begin
                sidx_reg <= col;
            end
        end
    end

    // a repeated maximum is also the second-sorted value
    assign second_idx = multi_reg ? tidx_reg : sidx_reg;

    assign result.first_page  = PAGE_W'(tidx_reg) + PAGE_W'(1);
    assign result.second_page = PAGE_W'(second_idx) + PAGE_W'(1);

endmodule

@@ sv/sppr_frames.sv @@
// ---------------------------------------------------------------------------
// sppr_frames
// Frame slot table: warm-up fill, hit search and victim choice.
// ---------------------------------------------------------------------------
module sppr_frames
    import sppr_pkg::*;
#(
    parameter int MAX_FRAMES = 4,
    parameter int SLOT_W     = 2,
    parameter int FILL_W     = 3
) (
    input  logic              clk,
    input  logic              rstn,
    input  logic [FILL_W-1:0] fc,
    input  logic [PAGE_W-1:0] page,
    input  frame_cmd_t        cmd,
    input  rank_result_t      pred,
    output frame_stat_t       stat,
    output logic [SLOT_W-1:0] slot,
    output logic [PAGE_W-1:0] evicted
);

    logic [PAGE_W-1:0] frame_reg [MAX_FRAMES];
    logic [FILL_W-1:0] filled_reg;
    logic [SLOT_W-1:0] fill_slot;
    logic [SLOT_W-1:0] victim;
    logic              hit;

    assign fill_slot = SLOT_W'(filled_reg);

    always_comb begin
        hit    = 1'b0;
        victim = '0;
        for (int i = 0; i < MAX_FRAMES; i++) begin
            if (i < int'(fc)) begin
                if (frame_reg[i] == page) begin
                    hit = 1'b1;
                end
                if (frame_reg[i] != pred.first_page && frame_reg[i] != pred.second_page) begin
                    victim = SLOT_W'(i);
                end
            end
        end
    end

    assign stat.warm = (filled_reg < fc);
    assign stat.hit  = hit;
    assign slot      = stat.warm ? fill_slot : victim;
    assign evicted   = stat.warm ? '0 : frame_reg[victim];

    always_ff @(posedge clk) begin
        if (!rstn) begin
            filled_reg <= '0;
            for (int i = 0; i < MAX_FRAMES; i++) begin
                frame_reg[i] <= '0;
            end
        end else begin
            if (cmd.fill) begin
                frame_reg[fill_slot] <= page;
                filled_reg           <= filled_reg + FILL_W'(1);
            end else if (cmd.replace) begin
                frame_reg[victim] <= page;
            end
        end
    end

endmodule

@@ sv/successor_predictive_page_replacement.sv @@
// ---------------------------------------------------------------------------
// successor_predictive_page_replacement
// Page replacement driven by learned page-to-successor transition counts.
// ---------------------------------------------------------------------------
// Usage: one page reference enters per s_valid/s_ready word on s_page; one
// result word leaves per m_valid/m_ready word. cfg_we/cfg_wdata set the
// number of frames in use; write it only while the block is idle.
// Sequence, one item at a time:
//   out-of-range page         : straight to the output state
//   warm-up fill or hit       : count read and write-back when a previous
//                               page exists, then check and output
//   miss                      : as above, then row scan, drain and apply
// The miss time is set by the count memory's single read port: the row of
// the referenced page streams out one count per cycle into the rank tracker.
// Reset (aresetn low, synchronous) clears the per-entry valid bits of the
// count memory at once, so no clearing pass is needed; frames, fault total
// and previous page return to zero and frame_count to 3.
// When the receiver stalls, the finished word waits in the output register;
// the block still takes the next page and works on it, then holds in its
// output state until the register is free.
// ---------------------------------------------------------------------------
`include "successor_predictive_page_replacement_macros.svh"

module successor_predictive_page_replacement
    import sppr_pkg::*;
#(
    parameter int NUM_PAGES  = 9,
    parameter int MAX_FRAMES = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PAGE_W-1:0]     s_page,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_fault,
    output logic [SLOT_OUT_W-1:0] m_slot,
    output logic [PAGE_W-1:0]     m_evicted_page,
    output logic [TOTAL_W-1:0]    m_fault_total,
    output logic                  m_bad_page
);

    localparam int CNT_DEPTH  = NUM_PAGES * NUM_PAGES;
    localparam int CNT_ADDR_W = $clog2(CNT_DEPTH);
    localparam int IDX_W      = $clog2(NUM_PAGES);
    localparam int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int FILL_W     = $clog2(MAX_FRAMES + 1);

    sppr_state_t state_reg, state_next;

    logic [CFG_W-1:0]      frame_count_reg;
    logic [FILL_W-1:0]     fc;
    logic [PAGE_W-1:0]     page_reg;
    logic [PAGE_W-1:0]     prev_reg;
    logic [IDX_W-1:0]      col_reg;
    logic [IDX_W-1:0]      col_d_reg;
    logic                  scan_live_reg;
    logic [TOTAL_W-1:0]    fault_cnt_reg;
    logic                  res_fault_reg;
    logic [SLOT_OUT_W-1:0] res_slot_reg;
    logic [PAGE_W-1:0]     res_evict_reg;
    logic                  res_bad_reg;
    logic                  m_valid_reg;
    logic                  m_fault_reg;
    logic [SLOT_OUT_W-1:0] m_slot_reg;
    logic [PAGE_W-1:0]     m_evict_reg;
    logic [TOTAL_W-1:0]    m_total_reg;
    logic                  m_bad_reg;

    logic                  in_bad;
    logic                  s_accept;
    logic                  out_load;
    logic                  scan_last;
    logic                  fault_evt;
    logic [CNT_ADDR_W-1:0] inc_addr;
    logic [CNT_ADDR_W-1:0] scan_addr;
    logic [CNT_ADDR_W-1:0] mem_rd_addr;
    logic [COUNT_BITS-1:0] mem_rd_data;
    logic [COUNT_BITS-1:0] mem_wr_data;
    logic                  mem_wr_en;
    frame_cmd_t            frame_cmd;
    frame_stat_t           frame_stat;
    rank_result_t          pred;
    logic [SLOT_W-1:0]     frame_slot;
    logic [PAGE_W-1:0]     frame_evicted;

    // clamp the frame count into 1..MAX_FRAMES
    always_comb begin
        if (frame_count_reg == '0) begin
            fc = FILL_W'(1);
        end else if (32'(frame_count_reg) > MAX_FRAMES) begin
            fc = FILL_W'(MAX_FRAMES);
        end else begin
            fc = FILL_W'(frame_count_reg);
        end
    end

    assign in_bad    = (s_page == '0) || (32'(s_page) > NUM_PAGES);
    assign s_accept  = s_valid && s_ready;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign scan_last = (col_reg == IDX_W'(NUM_PAGES - 1));
    assign fault_evt = frame_cmd.fill || frame_cmd.replace;

    assign inc_addr  = CNT_ADDR_W'((int'(prev_reg) - 1) * NUM_PAGES + int'(page_reg) - 1);
    assign scan_addr = CNT_ADDR_W'((int'(page_reg) - 1) * NUM_PAGES + int'(col_reg));

    // saturating increment of the count just read
    assign mem_wr_data = (mem_rd_data == '1) ? mem_rd_data : mem_rd_data + COUNT_BITS'(1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (in_bad) begin
                        state_next = ST_OUT;
                    end else if (prev_reg != '0) begin
                        state_next = ST_INC_RD;
                    end else begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_INC_RD: state_next = ST_INC_WR;
            ST_INC_WR: state_next = ST_CHECK;
            ST_CHECK: begin
                if (frame_stat.warm || frame_stat.hit) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_ready           = 1'b0;
        mem_rd_addr       = inc_addr;
        mem_wr_en         = 1'b0;
        frame_cmd.fill    = 1'b0;
        frame_cmd.replace = 1'b0;
        case (state_reg)
            ST_IDLE:   s_ready = 1'b1;
            ST_INC_WR: mem_wr_en = 1'b1;
            ST_CHECK:  frame_cmd.fill = frame_stat.warm;
            ST_SCAN:   mem_rd_addr = scan_addr;
            ST_APPLY:  frame_cmd.replace = 1'b1;
            default: begin
            end
        endcase
    end

    sppr_count_mem #(
        .DEPTH  (CNT_DEPTH),
        .ADDR_W (CNT_ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_count_mem (
        .clk     (aclk),
        .rstn    (aresetn),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (inc_addr),
        .wr_data (mem_wr_data)
    );

    sppr_rank #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_rank (
        .clk    (aclk),
        .sample (scan_live_reg),
        .col    (col_d_reg),
        .value  (mem_rd_data),
        .result (pred)
    );

    sppr_frames #(
        .MAX_FRAMES (MAX_FRAMES),
        .SLOT_W     (SLOT_W),
        .FILL_W     (FILL_W)
    ) u_frames (
        .clk     (aclk),
        .rstn    (aresetn),
        .fc      (fc),
        .page    (page_reg),
        .cmd     (frame_cmd),
        .pred    (pred),
        .stat    (frame_stat),
        .slot    (frame_slot),
        .evicted (frame_evicted)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            frame_count_reg <= FRAME_COUNT_RESET;
            prev_reg        <= '0;
            fault_cnt_reg   <= '0;
            scan_live_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            scan_live_reg <= (state_reg == ST_SCAN);
            if (cfg_we) begin
                frame_count_reg <= cfg_wdata;
            end
            if (fault_evt && fault_cnt_reg != '1) begin
                fault_cnt_reg <= fault_cnt_reg + TOTAL_W'(1);
            end
            if (out_load && !res_bad_reg) begin
                prev_reg <= page_reg;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            page_reg      <= s_page;
            res_bad_reg   <= in_bad;
            res_fault_reg <= 1'b0;
            res_slot_reg  <= '0;
            res_evict_reg <= '0;
        end
        if (fault_evt) begin
            res_fault_reg <= 1'b1;
            res_slot_reg  <= SLOT_OUT_W'(32'(frame_slot));
            res_evict_reg <= frame_evicted;
        end
        if (state_reg == ST_CHECK) begin
            col_reg <= '0;
        end else if (state_reg == ST_SCAN) begin
            col_reg <= col_reg + IDX_W'(1);
        end
        col_d_reg <= col_reg;
        if (out_load) begin
            m_fault_reg <= res_fault_reg;
            m_slot_reg  <= res_slot_reg;
            m_evict_reg <= res_evict_reg;
            m_total_reg <= fault_cnt_reg;
            m_bad_reg   <= res_bad_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_fault        = m_fault_reg;
    assign m_slot         = m_slot_reg;
    assign m_evicted_page = m_evict_reg;
    assign m_fault_total  = m_total_reg;
    assign m_bad_page     = m_bad_reg;

    `SPPR_ASSERT_IMP(a_no_write_in_scan, aclk, aresetn, state_reg == ST_SCAN, !mem_wr_en)
    `SPPR_ASSERT_NXT(a_bad_keeps_total, aclk, aresetn, s_accept && in_bad, $stable(fault_cnt_reg))
    `SPPR_ASSERT_IMP(a_bad_result_clean, aclk, aresetn, m_valid && m_bad_page, !m_fault && m_slot == '0 && m_evicted_page == '0)
    `SPPR_ASSERT_NXT(a_total_monotonic, aclk, aresetn, 1'b1, fault_cnt_reg >= $past(fault_cnt_reg))

endmodule

@@ dv/successor_predictive_page_replacement_tb.sv @@
// ---------------------------------------------------------------------------
// successor_predictive_page_replacement_tb
// Feeds page references through the replacement block. A cycle-free model of
// the transition counts and frame slots predicts the fault, slot, evicted
// page and fault total of every word, and each result word is compared in
// order. Runs cover warm-up, hits, misses, out-of-range pages, every frame
// count setting, and random gaps and stalls on both sides.
// ---------------------------------------------------------------------------
module successor_predictive_page_replacement_tb;
    import sppr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PAGES  = 9;
    localparam int MAX_FRAMES = 4;
    localparam int COUNT_BITS = 16;

    localparam int ITEMS_PER_PHASE = 68;
    localparam int SETTLE_CYCLES   = 40;
    localparam int LONG_HOLD       = 400;

    localparam logic [PAGE_W-1:0] DIRECTED_PAGES [23] = '{
        4'd0, 4'd10, 4'd15, 4'd1, 4'd1, 4'd9, 4'd1, 4'd9, 4'd2, 4'd8, 4'd3, 4'd15,
        4'd2, 4'd3, 4'd2, 4'd3, 4'd4, 4'd5, 4'd4, 4'd5, 4'd6, 4'd7, 4'd6
    };
    localparam logic [CFG_W-1:0] FRAME_SETTINGS [8] = '{
        3'd0, 3'd7, 3'd1, 3'd4, 3'd2, 3'd5, 3'd6, 3'd3
    };

    typedef struct packed {
        logic                  fault;
        logic [SLOT_OUT_W-1:0] slot;
        logic [PAGE_W-1:0]     evicted_page;
        logic [TOTAL_W-1:0]    fault_total;
        logic                  bad_page;
    } replace_word_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PAGE_W-1:0]     s_page = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_fault;
    logic [SLOT_OUT_W-1:0] m_slot;
    logic [PAGE_W-1:0]     m_evicted_page;
    logic [TOTAL_W-1:0]    m_fault_total;
    logic                  m_bad_page;

    // model state
    logic [COUNT_BITS-1:0] succ_cnt [NUM_PAGES][NUM_PAGES];
    logic [PAGE_W-1:0]     frame_pg [MAX_FRAMES];
    int                    filled;
    logic [PAGE_W-1:0]     prev_pg;
    logic [TOTAL_W-1:0]    fault_cnt;
    logic [CFG_W-1:0]      frames_cfg;

    logic [PAGE_W-1:0]     pages_to_send [$];
    replace_word_t         pending_results [$];
    int                    pages_queued = 0;
    int                    pages_accepted = 0;
    int                    fail_count = 0;
    bit                    idle_on = 1'b1;
    int                    tx_wait = 0;
    int                    rx_wait = 0;
    int                    rx_next;
    int                    rx_hold_left = 0;
    logic                  long_hold_req = 1'b0;
    logic                  hold_started = 1'b0;

    successor_predictive_page_replacement #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_FRAMES(MAX_FRAMES),
        .COUNT_BITS(COUNT_BITS)
    ) u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_page        (s_page),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_fault       (m_fault),
        .m_slot        (m_slot),
        .m_evicted_page(m_evicted_page),
        .m_fault_total (m_fault_total),
        .m_bad_page    (m_bad_page)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int draw_idle();
        return idle_on ? int'($urandom_range(0, 8)) : 0;
    endfunction

    // Advance the model by one reference and return the word it should produce.
    function automatic replace_word_t predict_replacement(logic [PAGE_W-1:0] pg);
        replace_word_t         res;
        int                    fc;
        int                    top_n;
        int                    victim;
        int                    i;
        logic [COUNT_BITS-1:0] top;
        logic [COUNT_BITS-1:0] runner_up;
        logic [COUNT_BITS-1:0] c;
        logic                  have_runner;
        logic                  hit;
        logic [PAGE_W-1:0]     first_pg;
        logic [PAGE_W-1:0]     second_pg;

        res = '0;
        if (pg < 1 || pg > NUM_PAGES) begin
            res.bad_page    = 1'b1;
            res.fault_total = fault_cnt;
            return res;
        end
        if (prev_pg != 0 && succ_cnt[prev_pg-1][pg-1] != '1) begin
            succ_cnt[prev_pg-1][pg-1] = succ_cnt[prev_pg-1][pg-1] + 1'b1;
        end
        fc = (frames_cfg == 0) ? 1 : ((frames_cfg > MAX_FRAMES) ? MAX_FRAMES : frames_cfg);

        if (filled < fc) begin
            // warm-up fills in order, even for a resident page
            res.slot = SLOT_OUT_W'(filled);
            frame_pg[filled] = pg;
            filled++;
            res.fault = 1'b1;
        end else begin
            hit = 1'b0;
            for (i = 0; i < fc; i++) begin
                if (frame_pg[i] == pg) hit = 1'b1;
            end
            if (!hit) begin
                top = '0;
                for (i = 0; i < NUM_PAGES; i++) begin
                    if (succ_cnt[pg-1][i] > top) top = succ_cnt[pg-1][i];
                end
                top_n = 0;
                for (i = 0; i < NUM_PAGES; i++) begin
                    if (succ_cnt[pg-1][i] == top) top_n++;
                end
                // a repeated maximum is also the runner-up value
                runner_up   = top;
                have_runner = 1'b0;
                if (top_n < 2) begin
                    runner_up = '0;
                    for (i = 0; i < NUM_PAGES; i++) begin
                        c = succ_cnt[pg-1][i];
                        if (c < top && (!have_runner || c > runner_up)) begin
                            runner_up   = c;
                            have_runner = 1'b1;
                        end
                    end
                end
                first_pg  = '0;
                second_pg = '0;
                for (i = 0; i < NUM_PAGES; i++) begin
                    if (succ_cnt[pg-1][i] == top) first_pg = PAGE_W'(i + 1);
                    if (succ_cnt[pg-1][i] == runner_up) second_pg = PAGE_W'(i + 1);
                end
                victim = 0;
                for (i = 0; i < fc; i++) begin
                    if (frame_pg[i] != first_pg && frame_pg[i] != second_pg) victim = i;
                end
                res.slot         = SLOT_OUT_W'(victim);
                res.evicted_page = frame_pg[victim];
                frame_pg[victim] = pg;
                res.fault        = 1'b1;
            end
        end
        if (res.fault && fault_cnt != '1) fault_cnt = fault_cnt + 1'b1;
        res.fault_total = fault_cnt;
        prev_pg = pg;
        return res;
    endfunction

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    task automatic clear_model();
        int a;
        int b;
        for (a = 0; a < NUM_PAGES; a++) begin
            for (b = 0; b < NUM_PAGES; b++) succ_cnt[a][b] = '0;
        end
        for (a = 0; a < MAX_FRAMES; a++) frame_pg[a] = '0;
        filled     = 0;
        prev_pg    = '0;
        fault_cnt  = '0;
        frames_cfg = FRAME_COUNT_RESET;
    endtask

    task automatic queue_page(logic [PAGE_W-1:0] pg);
        pages_to_send.push_back(pg);
        pages_queued++;
    endtask

    // Hold until every queued word is through and the block has settled.
    task automatic wait_drained();
        while (pages_accepted != pages_queued || pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_frame_count(logic [CFG_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        frames_cfg = value;
    endtask

    // Mostly a small working set so hits and learned predictions show up.
    function automatic logic [PAGE_W-1:0] rand_page(int base, int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) begin
            return ($urandom_range(0, 1) != 0) ? PAGE_W'(0) : PAGE_W'($urandom_range(10, 15));
        end else if (r < 65) begin
            return PAGE_W'(base + $urandom_range(0, span - 1));
        end
        return PAGE_W'($urandom_range(1, NUM_PAGES));
    endfunction

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_page  <= '0;
            tx_wait <= 0;
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(predict_replacement(s_page));
                pages_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (tx_wait != 0) begin
                    tx_wait <= tx_wait - 1;
                    s_valid <= 1'b0;
                end else if (pages_to_send.size() != 0) begin
                    s_valid <= 1'b1;
                    s_page  <= pages_to_send.pop_front();
                    tx_wait <= draw_idle();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait <= 0;
        end else begin
            rx_next = rx_wait;
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result word with no reference outstanding");
                    fail_count++;
                end else begin
                    replace_word_t want;
                    want = pending_results.pop_front();
                    check_field("fault", want.fault, m_fault);
                    check_field("slot", want.slot, m_slot);
                    check_field("evicted_page", want.evicted_page, m_evicted_page);
                    check_field("fault_total", want.fault_total, m_fault_total);
                    check_field("bad_page", want.bad_page, m_bad_page);
                end
                rx_next = draw_idle();
            end
            if (rx_hold_left != 0) begin
                m_ready <= 1'b0;
                rx_wait <= rx_next;
            end else if (rx_next != 0) begin
                m_ready <= 1'b0;
                rx_wait <= rx_next - 1;
            end else begin
                m_ready <= 1'b1;
                rx_wait <= 0;
            end
        end
    end

    // long receiver stall so the block backs up into its input
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold_left <= 0;
            hold_started <= 1'b0;
        end else if (long_hold_req && !hold_started) begin
            rx_hold_left <= LONG_HOLD;
            hold_started <= 1'b1;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
        end
    end

    initial begin
        int ph;
        int n;
        int span;
        int base;

        clear_model();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // out-of-range pages before any valid one, warm-up duplicates, hits,
        // first misses on empty count rows, out-of-range page mid-run
        foreach (DIRECTED_PAGES[k]) queue_page(DIRECTED_PAGES[k]);
        wait_drained();

        span = 3;
        base = 1;
        for (ph = 0; ph < $size(FRAME_SETTINGS); ph++) begin
            write_frame_count(FRAME_SETTINGS[ph]);
            idle_on = (ph != 1 && ph != 5);
            if (ph == 3) long_hold_req <= 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (n % 17 == 0) begin
                    span = $urandom_range(2, 5);
                    base = $urandom_range(1, NUM_PAGES - span + 1);
                end
                queue_page(rand_page(base, span));
            end
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #30_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
